// ----- src/rpd_pkg.sv -----
package rpd_pkg;

    localparam int HIST_DEPTH = 32;
    localparam int PAT_LEN    = 4;

    localparam int DUR_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int MEAN_W     = DUR_W + FRAC_W;
    localparam int CNT_W      = 16;
    localparam int DEN_W      = CNT_W + 1;
    localparam int PROD_W     = MEAN_W + CNT_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int DIV_CNT_W  = $clog2(MEAN_W + 1);
    localparam int REPS_W     = 5;
    localparam int HOLD_W     = 8;
    localparam int HOLD_ENT   = (PAT_LEN < 4) ? PAT_LEN : 4;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [REPS_W-1:0] REPS_MAX = '1;

    typedef logic [1:0] t_entry;

    typedef struct packed {
        logic take;
        logic mul;
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic scan_done;
    } t_sts;

endpackage

// ----- src/rpd_in_if.sv -----
interface rpd_in_if;
    logic                     valid;
    logic                     ready;
    logic                     event_is_burst;
    logic [rpd_pkg::DUR_W-1:0] duration_ms;

    modport source (output valid, output event_is_burst, output duration_ms, input ready);
    modport sink   (input valid, input event_is_burst, input duration_ms, output ready);
endinterface

// ----- src/rpd_out_if.sv -----
interface rpd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       long_flag;
    logic [rpd_pkg::REPS_W-1:0] pattern_reps;
    logic [rpd_pkg::HOLD_W-1:0] held_pattern;

    modport source (output valid, output long_flag, output pattern_reps,
                    output held_pattern, input ready);
    modport sink   (input valid, input long_flag, input pattern_reps,
                    input held_pattern, output ready);
endinterface

// ----- src/rpd_ctrl.sv -----
module rpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rpd_pkg::t_sts i_sts,
    output rpd_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_RUN,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.take   = i_in_valid;
            S_MUL:   o_cmd.mul    = 1'b1;
            S_LOAD:  o_cmd.load   = 1'b1;
            S_RUN:   o_cmd.step   = 1'b1;
            S_DONE:  o_cmd.finish = w_slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_MUL;
                end
                S_MUL:  r_state <= S_LOAD;
                S_LOAD: r_state <= S_RUN;
                S_RUN: begin
                    if (i_sts.div_done && i_sts.scan_done) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_slot_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_finish_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (i_sts.div_done && i_sts.scan_done))
        else $error("result loaded before divide and scan finished");
    a_take_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> o_cmd.mul ##1 o_cmd.load)
        else $error("accepted transaction did not start multiply and load");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.finish)
        else $error("pending result overwritten");
`endif

endmodule

// ----- src/rpd_dp.sv -----
module rpd_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rpd_pkg::t_cmd              i_cmd,
    output rpd_pkg::t_sts              o_sts,
    input  logic                       i_event_is_burst,
    input  logic [rpd_pkg::DUR_W-1:0]  i_duration_ms,
    output logic                       o_long_flag,
    output logic [rpd_pkg::REPS_W-1:0] o_pattern_reps,
    output logic [rpd_pkg::HOLD_W-1:0] o_held_pattern
);

    rpd_pkg::t_entry                     r_hist [rpd_pkg::HIST_DEPTH];
    rpd_pkg::t_entry                     r_scan [rpd_pkg::HIST_DEPTH];
    logic [rpd_pkg::FILL_W-1:0]          r_fill;
    logic [rpd_pkg::FILL_W-1:0]          r_scan_left;
    logic [rpd_pkg::REPS_W-1:0]          r_reps;
    logic [rpd_pkg::MEAN_W-1:0]          r_bmean;
    logic [rpd_pkg::MEAN_W-1:0]          r_smean;
    logic [rpd_pkg::CNT_W-1:0]           r_btotal;
    logic [rpd_pkg::CNT_W-1:0]           r_stotal;
    logic [rpd_pkg::HOLD_W-1:0]          r_hold;
    logic                                r_burst;
    logic                                r_is_long;
    logic [rpd_pkg::DUR_W-1:0]           r_dur;
    logic [rpd_pkg::CNT_W-1:0]           r_n;
    logic [rpd_pkg::DEN_W-1:0]           r_den;
    logic [rpd_pkg::PROD_W-1:0]          r_prod;
    logic [rpd_pkg::DEN_W-1:0]           r_rem;
    logic [rpd_pkg::MEAN_W-1:0]          r_quo;
    logic [rpd_pkg::DIV_CNT_W-1:0]       r_div_cnt;
    logic                                r_out_long;
    logic [rpd_pkg::REPS_W-1:0]          r_out_reps;

    logic [rpd_pkg::MEAN_W-1:0]          n_mean_in;
    logic [rpd_pkg::CNT_W-1:0]           n_total_in;
    logic                                n_is_long;
    logic [rpd_pkg::NUM_W-1:0]           n_num;
    logic [rpd_pkg::DEN_W:0]             n_trial;
    logic [rpd_pkg::DEN_W:0]             n_diff;
    logic                                n_ge;
    logic                                n_match;
    logic [rpd_pkg::HOLD_W-1:0]          n_pack;

    assign n_mean_in  = i_event_is_burst ? r_bmean : r_smean;
    assign n_total_in = i_event_is_burst ? r_btotal : r_stotal;
    assign n_is_long  = !((rpd_pkg::MEAN_W'(i_duration_ms) << rpd_pkg::FRAC_W) < n_mean_in);

    assign n_num = rpd_pkg::NUM_W'(r_prod)
                 + (rpd_pkg::NUM_W'(r_dur) << rpd_pkg::FRAC_W)
                 + rpd_pkg::NUM_W'(r_den >> 1);

    assign n_trial = {r_rem, r_quo[rpd_pkg::MEAN_W-1]};
    assign n_diff  = n_trial - {1'b0, r_den};
    assign n_ge    = (n_trial >= {1'b0, r_den});

    always_comb begin
        n_match = 1'b1;
        for (int k = 0; k < rpd_pkg::PAT_LEN; k++) begin
            if (r_scan[k] != r_hist[k]) n_match = 1'b0;
        end
    end

    always_comb begin
        n_pack = '0;
        for (int k = 0; k < rpd_pkg::HOLD_ENT; k++) begin
            n_pack[2*k +: 2] = r_hist[rpd_pkg::PAT_LEN-1-k];
        end
    end

    assign o_sts.div_done  = (r_div_cnt == '0);
    assign o_sts.scan_done = (r_scan_left == '0);

    assign o_long_flag     = r_out_long;
    assign o_pattern_reps  = r_out_reps;
    assign o_held_pattern  = r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rpd_pkg::HIST_DEPTH; k++) r_hist[k] <= '0;
            r_fill      <= '0;
            r_bmean     <= '0;
            r_smean     <= '0;
            r_btotal    <= '0;
            r_stotal    <= '0;
            r_hold      <= '0;
            r_div_cnt   <= '0;
            r_scan_left <= '0;
        end else begin
            if (i_cmd.take) begin
                r_hist[0] <= {n_is_long, i_event_is_burst};
                for (int k = 1; k < rpd_pkg::HIST_DEPTH; k++) r_hist[k] <= r_hist[k-1];
                if (r_fill != rpd_pkg::FILL_W'(rpd_pkg::HIST_DEPTH)) r_fill <= r_fill + 1'b1;
                if (i_event_is_burst) begin
                    if (r_btotal != rpd_pkg::CNT_MAX) r_btotal <= r_btotal + 1'b1;
                end else begin
                    if (r_stotal != rpd_pkg::CNT_MAX) r_stotal <= r_stotal + 1'b1;
                end
            end
            if (i_cmd.mul) begin
                if (r_fill >= rpd_pkg::FILL_W'(rpd_pkg::PAT_LEN)) begin
                    r_scan_left <= r_fill - rpd_pkg::FILL_W'(rpd_pkg::PAT_LEN) + 1'b1;
                end else begin
                    r_scan_left <= '0;
                end
            end
            if (i_cmd.load) r_div_cnt <= rpd_pkg::DIV_CNT_W'(rpd_pkg::MEAN_W);
            if (i_cmd.step) begin
                if (r_div_cnt != '0) r_div_cnt <= r_div_cnt - 1'b1;
                if (r_scan_left != '0) r_scan_left <= r_scan_left - 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_burst) begin
                    r_bmean <= r_quo;
                end else begin
                    r_smean <= r_quo;
                end
                if (r_reps > rpd_pkg::REPS_W'(1)) r_hold <= n_pack;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_burst   <= i_event_is_burst;
            r_is_long <= n_is_long;
            r_dur     <= i_duration_ms;
            r_n       <= n_total_in;
            r_den     <= rpd_pkg::DEN_W'(n_total_in) + 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= (r_burst ? r_bmean : r_smean) * r_n;
            r_reps <= '0;
            for (int k = 0; k < rpd_pkg::HIST_DEPTH; k++) r_scan[k] <= r_hist[k];
        end
        if (i_cmd.load) begin
            r_rem <= n_num[rpd_pkg::NUM_W-1 -: rpd_pkg::DEN_W];
            r_quo <= n_num[rpd_pkg::MEAN_W-1:0];
        end
        if (i_cmd.step) begin
            if (r_div_cnt != '0) begin
                r_rem <= n_ge ? n_diff[rpd_pkg::DEN_W-1:0] : n_trial[rpd_pkg::DEN_W-1:0];
                r_quo <= {r_quo[rpd_pkg::MEAN_W-2:0], n_ge};
            end
            if (r_scan_left != '0) begin
                if (n_match && (r_reps != rpd_pkg::REPS_MAX)) r_reps <= r_reps + 1'b1;
                for (int k = 0; k < rpd_pkg::HIST_DEPTH - 1; k++) r_scan[k] <= r_scan[k+1];
                r_scan[rpd_pkg::HIST_DEPTH-1] <= '0;
            end
        end
        if (i_cmd.finish) begin
            r_out_long <= r_is_long;
            r_out_reps <= (r_reps > rpd_pkg::REPS_W'(1)) ? r_reps : '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= rpd_pkg::FILL_W'(rpd_pkg::HIST_DEPTH))
        else $error("history fill above depth");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_left <= rpd_pkg::FILL_W'(rpd_pkg::HIST_DEPTH - rpd_pkg::PAT_LEN + 1))
        else $error("window scan count out of range");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_cnt != '0) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");
    a_div_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_div_cnt != '0) |=> (r_div_cnt == $past(r_div_cnt) - 1'b1))
        else $error("divider step count skipped");
`endif

endmodule

// ----- src/rhythm_pattern_detector.sv -----
// Rhythm pattern detector.
// i_event (sink): one transaction per finished burst or silence, with its duration in ms.
// o_result (source): one transaction per input: long/short flag, repeat count of the
//   newest window in the history (zero unless above one), and the last repeating window.
// Each event is classed against the running mean of its kind; the mean is then updated
// through a 24-step restoring divider, while a shift copy of the history is walked one
// window per cycle and compared with the newest window.
// The filled history holds at most 29 windows for the walk to compare. One transaction is
// in work at a time, and the next one can be taken as soon as the result turns valid.
// i_event.ready is high while no transaction is in work. A finished result waits in the
// output register; a new transaction can be taken while it waits, and the next result
// waits in the last control state until the receiver takes the previous one.
// Reset (synchronous, active low) clears the history, fill count, means, counts, held
// pattern and the output valid.
module rhythm_pattern_detector (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpd_in_if.sink    i_event,
    rpd_out_if.source o_result
);

    rpd_pkg::t_cmd w_cmd;
    rpd_pkg::t_sts w_sts;

    rpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_event.valid),
        .o_in_ready  (i_event.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rpd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_event_is_burst (i_event.event_is_burst),
        .i_duration_ms    (i_event.duration_ms),
        .o_long_flag      (o_result.long_flag),
        .o_pattern_reps   (o_result.pattern_reps),
        .o_held_pattern   (o_result.held_pattern)
    );

endmodule
